>>> rtl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, command and action codes, and entry/result types for the
// counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 8;
   localparam int COUNT_W = 16;
   localparam int WAIT_W  = 7;
   localparam int ACT_W   = 2;

   localparam int SEM_SLOTS_DEF   = 32;
   localparam int MAX_WAITERS_DEF = 64;

   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_P      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_V      = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BLOCK = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WAKE  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // one semaphore as stored in the table memory
   typedef struct packed {
      logic [WAIT_W-1:0]  waiters;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic              status;
      logic [ID_W-1:0]   new_id;
      logic [ACT_W-1:0]  action;
   } result_type;

endpackage

>>> rtl/cst_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_req_if
// Request channel: valid/ready handshake with command, id and initial value.
// ----------------------------------------------------------------------------
interface cst_req_if import cst_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [ID_W-1:0]           sem_id;
   logic signed [COUNT_W-1:0] init_value;

   modport source (output valid, output cmd, output sem_id, output init_value,
                   input ready);
   modport sink   (input valid, input cmd, input sem_id, input init_value,
                   output ready);
endinterface

>>> rtl/cst_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_rsp_if
// Response channel: valid/ready handshake with status, new id and action.
// ----------------------------------------------------------------------------
interface cst_rsp_if import cst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             status;
   logic [ID_W-1:0]  new_id;
   logic [ACT_W-1:0] action;

   modport source (output valid, output status, output new_id, output action,
                   input ready);
   modport sink   (input valid, input status, input new_id, input action,
                   output ready);
endinterface

>>> rtl/cst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cst_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_exec
// Decides one request against its table entry and the slot count: builds
// the response and the entry write-back.
// ----------------------------------------------------------------------------
module cst_exec import cst_pkg::*; #(
   parameter int SEM_SLOTS   = SEM_SLOTS_DEF,
   parameter int MAX_WAITERS = MAX_WAITERS_DEF,
   localparam int IDX_W      = $clog2(SEM_SLOTS),
   localparam int CNT_W      = $clog2(SEM_SLOTS + 1)
) (
   input  logic [CMD_W-1:0]          cmd,
   input  logic [ID_W-1:0]           sem_id,
   input  logic signed [COUNT_W-1:0] init_value,
   input  entry_type                 entry,
   input  logic [CNT_W-1:0]          slots_taken,
   output result_type                res,
   output logic                      wr_en,
   output logic [IDX_W-1:0]          wr_addr,
   output entry_type                 wr_data,
   output logic                      take_slot
);

   logic id_ok;
   logic full;

   // slots are never freed, so slot i is in use exactly when i < slots_taken
   assign id_ok = {{CNT_W{1'b0}}, sem_id} < {{ID_W{1'b0}}, slots_taken};
   assign full  = slots_taken == CNT_W'(SEM_SLOTS);

   always_comb begin
      res        = '{status: 1'b1, new_id: '0, action: ACT_NONE};
      wr_en      = 1'b0;
      wr_addr    = sem_id[IDX_W-1:0];
      wr_data    = entry;
      take_slot  = 1'b0;
      unique case (cmd)
         CMD_CREATE: begin
            wr_addr = slots_taken[IDX_W-1:0];
            if (!init_value[COUNT_W-1] && !full) begin
               wr_en         = 1'b1;
               wr_data       = '{waiters: '0, count: init_value};
               take_slot     = 1'b1;
               res.status    = 1'b0;
               res.new_id    = ID_W'(slots_taken);
            end
         end
         CMD_P: begin
            if (id_ok) begin
               if (entry.count == '0) begin
                  if (entry.waiters < WAIT_W'(MAX_WAITERS)) begin
                     wr_en           = 1'b1;
                     wr_data.waiters = entry.waiters + WAIT_W'(1);
                     res.status      = 1'b0;
                     res.action      = ACT_BLOCK;
                  end
               end else begin
                  wr_en         = 1'b1;
                  wr_data.count = entry.count - COUNT_W'(1);
                  res.status    = 1'b0;
               end
            end
         end
         CMD_V: begin
            if (id_ok) begin
               if (entry.waiters != '0) begin
                  wr_en           = 1'b1;
                  wr_data.waiters = entry.waiters - WAIT_W'(1);
                  res.status      = 1'b0;
                  res.action      = ACT_WAKE;
               end else if (entry.count != COUNT_MAX) begin
                  wr_en         = 1'b1;
                  wr_data.count = entry.count + COUNT_W'(1);
                  res.status    = 1'b0;
               end
            end
         end
         default: begin
            res.status = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/counting_semaphore_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of counting semaphores serving create, P and V requests.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the response side stalls, and returns
// one response per request, in order, from the output register after the
// execute stage. The counts and waiter counts sit in one RAM with a
// registered read: the entry is read when a request is accepted and
// written back as it leaves the execute stage; a request accepted as that
// entry is written takes the new value from a bypass register. Slots are
// given lowest first, never freed: the table needs no clearing after reset.
module counting_semaphore_table import cst_pkg::*; #(
   parameter int SEM_SLOTS   = SEM_SLOTS_DEF,
   parameter int MAX_WAITERS = MAX_WAITERS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_if,
   cst_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(SEM_SLOTS);
   localparam int CNT_W = $clog2(SEM_SLOTS + 1);

   // execute stage
   logic                      s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]          s1_cmd_ff;
   logic [ID_W-1:0]           s1_id_ff;
   logic signed [COUNT_W-1:0] s1_init_ff;
   logic                      byp_valid_ff, byp_valid_in;
   entry_type                 byp_data_ff;

   logic [CNT_W-1:0]          slots_taken_ff, slots_taken_in;

   logic                      out_valid_ff, out_valid_in;
   result_type                out_res_ff;

   logic                      s1_fire;
   logic                      req_accept;
   entry_type                 ram_rd_data;
   entry_type                 entry;
   result_type                res;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   entry_type                 wr_data;
   logic                      take_slot;

   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_accept = req_if.valid && req_if.ready;

   cst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SEM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_fire && wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_if.sem_id[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign entry = byp_valid_ff ? byp_data_ff : ram_rd_data;

   cst_exec #(
      .SEM_SLOTS   (SEM_SLOTS),
      .MAX_WAITERS (MAX_WAITERS)
   ) u_exec (
      .cmd         (s1_cmd_ff),
      .sem_id      (s1_id_ff),
      .init_value  (s1_init_ff),
      .entry       (entry),
      .slots_taken (slots_taken_ff),
      .res         (res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .take_slot   (take_slot)
   );

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      byp_valid_in   = byp_valid_ff;
      out_valid_in   = out_valid_ff;
      slots_taken_in = slots_taken_ff;
      if (s1_fire) begin
         s1_valid_in  = 1'b0;
         byp_valid_in = 1'b0;
         out_valid_in = 1'b1;
         if (take_slot) begin
            slots_taken_in = slots_taken_ff + CNT_W'(1);
         end
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         // RAM returns the old word when the same entry is written this cycle
         byp_valid_in = s1_fire && wr_en && (wr_addr == req_if.sem_id[IDX_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         byp_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
         slots_taken_ff <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         byp_valid_ff   <= byp_valid_in;
         out_valid_ff   <= out_valid_in;
         slots_taken_ff <= slots_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= req_if.cmd;
         s1_id_ff    <= req_if.sem_id;
         s1_init_ff  <= req_if.init_value;
         byp_data_ff <= wr_data;
      end
      if (s1_fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.status = out_res_ff.status;
   assign rsp_if.new_id = out_res_ff.new_id;
   assign rsp_if.action = out_res_ff.action;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_taken_bound : assert property (@(posedge clock) disable iff (reset)
      slots_taken_ff <= CNT_W'(SEM_SLOTS))
      else $error("slot count exceeds table size");

   a_taken_step : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && take_slot) |=> (slots_taken_ff == $past(slots_taken_ff) + CNT_W'(1)))
      else $error("successful create did not claim a slot");

   a_error_clean : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_res_ff.status) |->
         (out_res_ff.action == ACT_NONE && out_res_ff.new_id == '0))
      else $error("error response carries an action or id");

   a_stall : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("request taken while the pipeline is stalled");

   a_byp_owner : assert property (@(posedge clock) disable iff (reset)
      byp_valid_ff |-> s1_valid_ff)
      else $error("bypass armed with no request in execute stage");

endmodule
